@@ rtl/asdb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan and keypad debounce package
// Shared types and constants for the ADC channel scanner and ladder keypad.
// ----------------------------------------------------------------------------
package asdb_pkg;

  localparam int SAMPLE_W = 10;
  localparam int CHAN_W   = 3;
  localparam int NUM_KEYS = 6;
  localparam int CNT_W    = 8;
  localparam int NUM_SLOTS = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;

  localparam logic [CNT_W-1:0] CNT_MAX       = 8'hFF;
  localparam logic [CNT_W-1:0] LIMIT_DEFAULT = 8'd20;

  localparam logic [CHAN_W-1:0] CH_POT_ZERO = 3'd0;
  localparam logic [CHAN_W-1:0] CH_POT_ONE  = 3'd1;
  localparam logic [CHAN_W-1:0] CH_HALL     = 3'd2;
  localparam logic [CHAN_W-1:0] CH_TEMP     = 3'd3;
  localparam logic [CHAN_W-1:0] CH_LIGHT    = 3'd4;
  localparam logic [CHAN_W-1:0] CH_KEYPAD   = 3'd7;

  localparam logic [SAMPLE_W-1:0] WIN_LO [NUM_KEYS] = '{
    10'h000, 10'h08b, 10'h120, 10'h1b9, 10'h248, 10'h2d3
  };
  localparam logic [SAMPLE_W-1:0] WIN_HI [NUM_KEYS] = '{
    10'h010, 10'h0ab, 10'h140, 10'h1d9, 10'h268, 10'h2f3
  };

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] press;
    logic                key_hit;
  } scan_status_t;

endpackage : asdb_pkg
`default_nettype wire

@@ rtl/asdb_key_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad window scan and debounce
// Compares a ladder sample against six key windows, runs one debounce
// counter per key and keeps the sticky press bits.
// ----------------------------------------------------------------------------
module asdb_key_scan (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        scan_en,
  input  wire asdb_pkg::sample_t           sample,
  input  wire logic [asdb_pkg::CNT_W-1:0]  limit,
  output asdb_pkg::scan_status_t           status
);
  import asdb_pkg::*;

  logic [CNT_W-1:0]    cnt_r   [NUM_KEYS];
  logic [CNT_W-1:0]    cnt_nxt [NUM_KEYS];
  logic [NUM_KEYS-1:0] press_r;
  logic [NUM_KEYS-1:0] press_nxt;
  logic [NUM_KEYS-1:0] in_win;
  logic                hit;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      in_win[k] = (sample >= WIN_LO[k]) && (sample <= WIN_HI[k]);
    end
  end

  always_comb begin
    hit       = 1'b0;
    press_nxt = press_r;
    for (int k = 0; k < NUM_KEYS; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if (scan_en) begin
        if (!in_win[k]) begin
          cnt_nxt[k] = '0;
        end else if (cnt_r[k] == limit) begin
          press_nxt[k] = 1'b1;
          hit          = 1'b1;
          if (cnt_r[k] != CNT_MAX) begin
            cnt_nxt[k] = cnt_r[k] + 1'b1;
          end
        end else if (cnt_r[k] < limit) begin
          cnt_nxt[k] = cnt_r[k] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      press_r <= press_nxt;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  assign status.press   = press_nxt;
  assign status.key_hit = hit;

  a_press_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((press_r & $past(press_r)) == $past(press_r)))
    else $error("press bit cleared outside reset");

  a_hit_sets_press: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (scan_en && (press_nxt & in_win) != '0))
    else $error("key hit without an in-window press");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !scan_en |=> $stable(press_r) && $stable(cnt_r[0]))
    else $error("key state changed without a keypad sample");

endmodule : asdb_key_scan
`default_nettype wire

@@ rtl/adc_scan_ladder_key_debounce_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan with resistor-ladder keypad debounce
// Walks ADC channels 0..7, stores the samples of channels 0-4 and 7 and
// debounces six ladder keys on channel 7.
// ----------------------------------------------------------------------------
// Channel  Dir  Content
// in_      in   one conversion result per transfer
// out_     out  channel, stored samples, press bits, event, next channel
// cfg_     in   debounce limit write
//
// One conversion per cycle unless out_tready stalls; each result is ready in
// the cycle after its transfer, from the register behind the window compare.
// in_tready stays high while the result register is empty or being taken.
// Reset clears the channel ring, stored samples, counters and press bits
// and loads a debounce limit of 20.
// ----------------------------------------------------------------------------
module adc_scan_ladder_key_debounce_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // [7:0] result_high, [9:8] result_low
  input  wire logic [asdb_pkg::IN_TDATA_W-1:0]   in_tdata,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // [2:0] channel_done, [12:3] pot_zero_value, [22:13] pot_one_value,
  // [32:23] hall_value, [42:33] temp_value, [52:43] light_value,
  // [62:53] keypad_value, [68:63] key_pressed, [69] key_event,
  // [72:70] next_channel
  output      logic [asdb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [asdb_pkg::CNT_W-1:0]        cfg_wr_data
);
  import asdb_pkg::*;

  logic                  in_xfer;
  sample_t               sample;
  logic [CHAN_W-1:0]     chan_r;
  logic [CHAN_W-1:0]     chan_nxt;
  sample_t               store_r   [NUM_SLOTS];
  sample_t               store_nxt [NUM_SLOTS];
  logic [CNT_W-1:0]      limit_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic                  scan_en;
  scan_status_t          scan_status;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign sample    = {in_tdata[7:0], in_tdata[9:8]};
  assign chan_nxt  = chan_r + 1'b1;
  assign scan_en   = in_xfer && (chan_r == CH_KEYPAD);

  asdb_key_scan u_key_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .scan_en (scan_en),
    .sample  (sample),
    .limit   (limit_r),
    .status  (scan_status)
  );

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      store_nxt[i] = store_r[i];
    end
    unique case (chan_r)
      CH_POT_ZERO: store_nxt[0] = sample;
      CH_POT_ONE:  store_nxt[1] = sample;
      CH_HALL:     store_nxt[2] = sample;
      CH_TEMP:     store_nxt[3] = sample;
      CH_LIGHT:    store_nxt[4] = sample;
      CH_KEYPAD:   store_nxt[5] = sample;
      default:     ;
    endcase
  end

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[2:0]   = chan_r;
    out_data_nxt[12:3]  = store_nxt[0];
    out_data_nxt[22:13] = store_nxt[1];
    out_data_nxt[32:23] = store_nxt[2];
    out_data_nxt[42:33] = store_nxt[3];
    out_data_nxt[52:43] = store_nxt[4];
    out_data_nxt[62:53] = store_nxt[5];
    out_data_nxt[68:63] = scan_status.press;
    out_data_nxt[69]    = scan_status.key_hit;
    out_data_nxt[72:70] = chan_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= '0;
      limit_r     <= LIMIT_DEFAULT;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        chan_r      <= chan_nxt;
        out_valid_r <= 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          store_r[i] <= store_nxt[i];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_ring_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> chan_r == $past(chan_nxt))
    else $error("channel ring did not advance on transfer");

  a_event_keypad_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[69]) |-> out_data_r[2:0] == CH_KEYPAD)
    else $error("key event on a non-keypad channel");

  a_next_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[72:70] == chan_r))
    else $error("result next channel differs from ring state");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule : adc_scan_ladder_key_debounce_unit
`default_nettype wire
